// ===== sv/itor_pkg.sv =====
package itor_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;
  localparam int BASE_W = 6;
  localparam int CHAR_W = 8;

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] DIGIT_NINE = 6'd9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_NINE) begin
      c = CHAR_W'(d) - CHAR_W'(BASE_DEC) + CHAR_LOWER_A;
    end else begin
      c = CHAR_W'(d) + CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

// ===== sv/itor_div.sv =====
module itor_div #(
  parameter int VALUE_BITS = itor_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [VALUE_BITS-1:0]      dividend,
  input  logic [itor_pkg::BASE_W-1:0] divisor,
  output itor_pkg::div_status_t      status,
  output logic [VALUE_BITS-1:0]      quo,
  output logic [itor_pkg::BASE_W-1:0] rem
);
  import itor_pkg::*;

  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [BASE_W-1:0] dsr;
  logic [BASE_W:0]  rem_sh;
  logic             fits;

  // one restoring step per cycle, msb first
  assign rem_sh = {rem, quo[VALUE_BITS-1]};
  assign fits = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(VALUE_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[VALUE_BITS-2:0], fits};
      rem <= fits ? BASE_W'(rem_sh - {1'b0, dsr}) : BASE_W'(rem_sh);
    end
  end

  assign status.done = done;
  assign status.busy = busy;

endmodule

// ===== sv/integer_to_text_radix_core.sv =====
// Converts one two's-complement value to ASCII text in a base from 2 to 36, most
// significant character first, with last set on the final beat. Digits above 9 are
// 'a'..'z'; a negative value in base 10 is preceded by '-', in other bases it is taken
// as unsigned. One item at a time: in_ready is high only when idle. Each digit is the
// remainder of the shared bit-serial divider, stored least significant first; each
// character is then read from that store and held until out_ready, after the sign
// if there is one.
module integer_to_text_radix_core #(
  parameter int VALUE_BITS = itor_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itor_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_BITS-1:0]  value,
  input  logic [itor_pkg::BASE_W-1:0]   base,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itor_pkg::CHAR_W-1:0]   character,
  output logic                          last
);
  import itor_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  state_t state, state_next;

  logic [VALUE_BITS-1:0] quotient;
  logic [CNT_W-1:0]      count;
  logic                  neg;
  logic [BASE_W-1:0]     base_r;
  logic [BASE_W-1:0]     base_sat;
  logic [VALUE_BITS-1:0] q_in;
  logic                  neg_in;
  logic [CNT_W-1:0]      limit;
  logic [CNT_W-1:0]      count_m1;
  logic                  q_zero;

  logic [BASE_W-1:0]     mem [MAX_DIGITS];
  logic [BASE_W-1:0]     rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [BASE_W-1:0]     wr_data;
  logic                  rd_en;

  logic                  div_start;
  div_status_t           div_status;
  logic [VALUE_BITS-1:0] div_quo;
  logic [BASE_W-1:0]     div_rem;

  itor_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (quotient),
    .divisor  (base_r),
    .status   (div_status),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    if (base < BASE_MIN) begin
      base_sat = BASE_MIN;
    end else if (base > BASE_MAX) begin
      base_sat = BASE_MAX;
    end else begin
      base_sat = base;
    end
    neg_in = value[VALUE_BITS-1] && (base_sat == BASE_DEC);
    q_in = neg_in ? VALUE_BITS'(~value + 1'b1) : VALUE_BITS'(value);
  end

  assign limit = neg ? CNT_W'(MAX_DIGITS - 1) : CNT_W'(MAX_DIGITS);
  assign count_m1 = count - 1'b1;
  assign q_zero = quotient == '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (q_zero || count == limit) begin
          state_next = neg ? ST_SIGN : ST_READ;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) state_next = ST_CHECK;
      end
      ST_SIGN: begin
        if (out_ready) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) state_next = (count == CNT_W'(1)) ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    character = CHAR_ZERO;
    last = 1'b0;
    div_start = 1'b0;
    wr_en = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = div_rem;
    rd_en = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CHECK: begin
        if (q_zero && count == '0) begin
          wr_en = 1'b1;
          wr_data = '0;
        end else if (!q_zero && count != limit) begin
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        wr_en = div_status.done;
      end
      ST_SIGN: begin
        out_valid = 1'b1;
        character = CHAR_MINUS;
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        character = digit_char(rd_data);
        last = count == CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      quotient <= '0;
      neg <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            quotient <= q_in;
            neg <= neg_in;
            count <= '0;
          end
        end
        ST_CHECK: begin
          if (q_zero && count == '0) count <= CNT_W'(1);
        end
        ST_DIV: begin
          if (div_status.done) begin
            quotient <= div_quo;
            count <= count + 1'b1;
          end
        end
        ST_SHOW: begin
          if (out_ready) count <= count_m1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) base_r <= base_sat;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[count_m1[IDX_W-1:0]];
  end

endmodule

// ===== tb/sv/integer_to_text_radix_checker.sv =====
`timescale 1ns / 1ps

module integer_to_text_radix_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [31:0]           value,
  input  logic [itor_pkg::BASE_W-1:0]  base,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [itor_pkg::CHAR_W-1:0]  character,
  input  logic                         last,
  output int                           errors,
  output int                           pending,
  output int                           chars_seen
);

  import itor_pkg::*;

  localparam int DIGITS_MAX = MAX_DIGITS_DEF;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              tail;
  } text_beat_t;

  text_beat_t expected_text[$];

  // radix conversion of one value, characters queued most significant first
  function automatic void predict_text(input logic [31:0] raw, input logic [BASE_W-1:0] radix_in);
    logic [BASE_W-1:0] radix;
    logic [31:0]       mag;
    logic              minus;
    logic [BASE_W-1:0] digit_buf[DIGITS_MAX];
    logic [BASE_W-1:0] d;
    int                n;
    int                room;
    text_beat_t        beat;
    radix = radix_in;
    if (radix < BASE_MIN) radix = BASE_MIN;
    if (radix > BASE_MAX) radix = BASE_MAX;
    minus = raw[31] && (radix == BASE_DEC);
    mag = minus ? -raw : raw;
    room = minus ? DIGITS_MAX - 1 : DIGITS_MAX;
    n = 0;
    if (mag == 32'd0) begin
      digit_buf[0] = '0;
      n = 1;
    end else begin
      while (mag != 32'd0 && n < room) begin
        digit_buf[n] = BASE_W'(mag % radix);
        mag = mag / radix;
        n++;
      end
    end
    if (minus) begin
      beat.ch = CHAR_MINUS;
      beat.tail = 1'b0;
      expected_text.push_back(beat);
    end
    for (int k = n - 1; k >= 0; k--) begin
      d = digit_buf[k];
      beat.ch = (d > DIGIT_NINE) ? CHAR_W'(d) - CHAR_W'(BASE_DEC) + CHAR_LOWER_A
                                 : CHAR_W'(d) + CHAR_ZERO;
      beat.tail = (k == 0);
      expected_text.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    text_beat_t want;
    int         bad;
    bad = 0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        chars_seen <= chars_seen + 1;
        if (expected_text.size() == 0) begin
          $error("character beat with nothing expected: character %h last %b", character, last);
          bad++;
        end else begin
          want = expected_text.pop_front();
          if (character !== want.ch) begin
            $error("character: expected %h, actual %h", want.ch, character);
            bad++;
          end
          if (last !== want.tail) begin
            $error("last: expected %b, actual %b", want.tail, last);
            bad++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_text(value, base);
      end
    end
    errors <= errors + bad;
    pending <= expected_text.size();
  end

endmodule

// ===== tb/sv/integer_to_text_radix_core_test.sv =====
`timescale 1ns / 1ps

module integer_to_text_radix_core_test;

  import itor_pkg::*;

  localparam int RANDOM_ITEMS = 310;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 400;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [31:0]        value = '0;
  logic [BASE_W-1:0]         base = BASE_DEC;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [CHAR_W-1:0]         character;
  logic                      last;

  int   errors;
  int   pending;
  int   chars_seen;
  int   items_sent = 0;
  int   directed_items = 0;
  int   quiet_cycles = 0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_to_text_radix_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .base      (base),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  integer_to_text_radix_checker text_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .base       (base),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .character  (character),
    .last       (last),
    .errors     (errors),
    .pending    (pending),
    .chars_seen (chars_seen)
  );

  task automatic send_value(input logic signed [31:0] v, input logic [BASE_W-1:0] b);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    base <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(9))
      5: v = $urandom_range(40);
      6: v = -$signed(32'($urandom_range(1000, 1)));
      7: v = $urandom >> $urandom_range(31);
      8: begin
        case ($urandom_range(4))
          0: v = 32'h0;
          1: v = 32'h1;
          2: v = 32'hffffffff;
          3: v = 32'h7fffffff;
          default: v = 32'h80000000;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // receiver: random back-pressure, plus long hold-offs on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // watchdog on cycles without any beat
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("integer_to_text_radix_core_test: FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero, single digits, extremes, sign handling
    send_value(32'sd0, BASE_DEC);
    send_value(32'sd0, BASE_MIN);
    send_value(32'sd0, BASE_MAX);
    send_value(32'sd1, BASE_MIN);
    send_value(32'sd9, BASE_DEC);
    send_value(32'sd10, BASE_DEC);
    send_value(32'sd35, BASE_MAX);
    send_value(32'sd36, BASE_MAX);
    send_value(-32'sd1, BASE_DEC);
    send_value(-32'sd1, BASE_MIN);
    send_value(-32'sd1, 6'd16);
    send_value(32'h7fffffff, BASE_DEC);
    send_value(32'h80000000, BASE_DEC);
    send_value(32'h80000000, BASE_MIN);
    send_value(32'h80000000, 6'd16);
    send_value(-32'sd123456789, BASE_DEC);
    send_value(32'sd255, 6'd16);
    send_value(32'sd12345, 6'd7);
    send_value(32'hdeadbeef, BASE_MAX);
    send_value(32'h5a5a5a5a, 6'd3);
    // bases outside 2..36 saturate
    send_value(32'sd5, 6'd0);
    send_value(-32'sd7, 6'd1);
    send_value(32'sd1295, 6'd37);
    send_value(-32'sd1, 6'd63);
    directed_items = items_sent;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 40 || i == 220) hold_req = 1'b1;
      if (i == 120) calm = 1'b1;
      if (i == 190) calm = 1'b0;
      send_value(pick_value(),
                 ($urandom_range(3) == 0) ? BASE_DEC : BASE_W'($urandom_range(36, 2)));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d values (%0d directed) into %0d characters", items_sent,
             directed_items, chars_seen);
    $display("bases 0..63 incl. saturation, random back-pressure and two long receiver holds");
    if (errors == 0 && pending == 0) begin
      $display("integer_to_text_radix_core_test: PASS");
    end else begin
      $display("integer_to_text_radix_core_test: FAIL");
    end
    $finish;
  end

endmodule
